// ===== rtl/drrip_pkg.sv =====
package drrip_pkg;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int DUEL_PERIOD  = 32;
  localparam int COUNTER_BITS = 10;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = 4;
  localparam int MASK_W  = 16;
  localparam int DRAW_W  = 5;
  localparam int RR_W    = 2;
  localparam int ROW_W   = RR_W * NUM_WAYS;
  localparam int PHASE_W = $clog2(DUEL_PERIOD);

  localparam logic [RR_W-1:0] RR_MAX  = 2'd3;
  localparam logic [RR_W-1:0] RR_LONG = 2'd2;
  localparam logic [RR_W-1:0] RR_HOT  = 2'd0;

  localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};
  localparam logic [COUNTER_BITS-1:0] CTR_MID = CTR_MAX >> 1;

  localparam logic [PHASE_W-1:0] PHASE_SRRIP = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PHASE_BRRIP = PHASE_W'(1);

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic exec;
  } drrip_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_hold;
  } drrip_sts_t;

endpackage

// ===== rtl/drrip_ctrl.sv =====
module drrip_ctrl
  import drrip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  drrip_sts_t sts,
  output drrip_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.clr_step = 1'b0;
    cmd.exec     = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // wait while the previous result is still unclaimed
        if (!sts.out_hold) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== rtl/drrip_dp.sv =====
module drrip_dp
  import drrip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  drrip_cmd_t        cmd,
  output drrip_sts_t        sts,
  input  logic              in_operation,
  input  logic [SET_W-1:0]  in_set_index,
  input  logic [WAY_W-1:0]  in_way_index,
  input  logic              in_was_hit,
  input  logic [MASK_W-1:0] in_valid_mask,
  input  logic [DRAW_W-1:0] in_random_draw,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAY_W-1:0]  out_victim_way,
  output logic              out_victim_invalid
);

  // captured item
  logic              op_r;
  logic [SET_W-1:0]  set_r;
  logic [WAY_W-1:0]  way_r;
  logic              hit_r;
  logic [MASK_W-1:0] mask_r;
  logic [DRAW_W-1:0] draw_r;

  // re-reference rows
  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rdata_r;
  logic [SET_W-1:0] clr_idx_r;
  logic [SET_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;
  logic             wr_en;

  logic [COUNTER_BITS-1:0] ctr_r, ctr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [WAY_W-1:0]        out_way_r;
  logic                    out_inv_r;

  // search / update datapath
  logic             has_invalid;
  logic [WAY_W-1:0] inv_way;
  logic             any3, any2, any1;
  logic [RR_W-1:0]  add;
  logic [ROW_W-1:0] aged_row;
  logic [WAY_W-1:0] age_way;
  logic [PHASE_W-1:0] phase;
  logic             use_brrip;
  logic [RR_W-1:0]  ins_val;
  logic [ROW_W-1:0] upd_row;
  logic [WAY_W-1:0] res_way;
  logic             res_inv;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      set_r  <= in_set_index;
      way_r  <= in_way_index;
      hit_r  <= in_was_hit;
      mask_r <= in_valid_mask;
      draw_r <= in_random_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + SET_W'(1);
    end
  end

  assign sts.clr_last = (clr_idx_r == SET_W'(NUM_SETS - 1));
  assign sts.out_hold = out_valid_r && !out_ready;

  always_comb begin
    has_invalid = 1'b0;
    inv_way     = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!mask_r[w]) begin
        has_invalid = 1'b1;
        inv_way     = WAY_W'(w);
      end
    end
  end

  // age every way by the amount that lifts the top value to 3
  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (rdata_r[w*RR_W +: RR_W] == 2'd3);
      any2 = any2 | (rdata_r[w*RR_W +: RR_W] == 2'd2);
      any1 = any1 | (rdata_r[w*RR_W +: RR_W] == 2'd1);
    end
    if (any3) begin
      add = 2'd0;
    end else if (any2) begin
      add = 2'd1;
    end else if (any1) begin
      add = 2'd2;
    end else begin
      add = 2'd3;
    end
  end

  always_comb begin
    age_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[w*RR_W +: RR_W] = rdata_r[w*RR_W +: RR_W] + add;
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged_row[w*RR_W +: RR_W] == RR_MAX) begin
        age_way = WAY_W'(w);
      end
    end
  end

  // leader sets steer the counter, followers obey it
  assign phase = set_r[PHASE_W-1:0];

  always_comb begin
    ctr_nxt   = ctr_r;
    use_brrip = (ctr_r < CTR_MID);
    if (phase == PHASE_SRRIP) begin
      use_brrip = 1'b0;
      if (ctr_r != '0) begin
        ctr_nxt = ctr_r - COUNTER_BITS'(1);
      end
    end else if (phase == PHASE_BRRIP) begin
      use_brrip = 1'b1;
      if (ctr_r != CTR_MAX) begin
        ctr_nxt = ctr_r + COUNTER_BITS'(1);
      end
    end
  end

  always_comb begin
    if (hit_r) begin
      ins_val = RR_HOT;
    end else if (!use_brrip) begin
      ins_val = RR_LONG;
    end else if (draw_r == '0) begin
      ins_val = RR_HOT;
    end else begin
      ins_val = RR_MAX;
    end
    upd_row = rdata_r;
    upd_row[way_r*RR_W +: RR_W] = ins_val;
  end

  always_comb begin
    if (op_r == OP_UPDATE) begin
      res_way = '0;
      res_inv = 1'b0;
    end else if (has_invalid) begin
      res_way = inv_way;
      res_inv = 1'b1;
    end else begin
      res_way = age_way;
      res_inv = 1'b0;
    end
  end

  assign wr_en   = cmd.clr_step || (cmd.exec && (op_r == OP_UPDATE || !has_invalid));
  assign wr_addr = cmd.clr_step ? clr_idx_r : set_r;
  assign wr_data = cmd.clr_step ? {ROW_W{1'b1}} :
                   (op_r == OP_UPDATE) ? upd_row : aged_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[set_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= CTR_MID;
    end else if (cmd.exec && op_r == OP_UPDATE && !hit_r) begin
      ctr_r <= ctr_nxt;
    end
  end

  // output register
  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_way_r <= res_way;
      out_inv_r <= res_inv;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_victim_way     = out_way_r;
  assign out_victim_invalid = out_inv_r;

endmodule

// ===== rtl/drrip_cache_replacement.sv =====
// DRRIP cache replacement, 2-bit re-reference values, set dueling.
// Input channel (in_valid/in_ready): one item per request. operation 0 asks
// for a victim in set_index given valid_mask; operation 1 records an access
// to way_index (was_hit, random_draw pick the insertion value on a miss).
// Output channel (out_valid/out_ready): exactly one item per input item,
// carrying victim_way and victim_invalid (both 0 for an update).
// From accept to out_valid an item passes capture, row read and execute.
// A new item is accepted only after the previous one executes, as each
// set row goes through a read-modify-write in the row memory.
// Output register: a finished result waits there; a new item is accepted
// meanwhile and only its execute step waits while out_ready is low.
// Reset (rst_n, synchronous): the dueling counter goes to mid-scale and a
// clearing pass writes every set row to all-cold, one row per cycle;
// in_ready stays low until it completes.
module drrip_cache_replacement
  import drrip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [SET_W-1:0]  in_set_index,
  input  logic [WAY_W-1:0]  in_way_index,
  input  logic              in_was_hit,
  input  logic [MASK_W-1:0] in_valid_mask,
  input  logic [DRAW_W-1:0] in_random_draw,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAY_W-1:0]  out_victim_way,
  output logic              out_victim_invalid
);

  drrip_cmd_t cmd;
  drrip_sts_t sts;

  // sequencer: clear pass, accept, read, execute
  drrip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // row memory, aging/insertion logic, dueling counter, result register
  drrip_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_set_index       (in_set_index),
    .in_way_index       (in_way_index),
    .in_was_hit         (in_was_hit),
    .in_valid_mask      (in_valid_mask),
    .in_random_draw     (in_random_draw),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_victim_way     (out_victim_way),
    .out_victim_invalid (out_victim_invalid)
  );

endmodule
